// File: hdl/scgi_header_stream_parser_macros.svh
// assertion helpers used by the checker file
// each macro expects clk and rst to exist in the enclosing module
`ifndef SCGI_HEADER_STREAM_PARSER_MACROS_SVH
`define SCGI_HEADER_STREAM_PARSER_MACROS_SVH

// same-cycle implication, off during reset
`define SCGI_ASSERT_NOW(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// next-cycle implication, off during reset
`define SCGI_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

// File: hdl/scgi_pkg.sv
`timescale 1ns / 1ps

package scgi_pkg;

  // default width of the header length counter
  localparam int LENGTH_BITS_DEF = 16;

  // reset value of the pair limit register
  localparam logic [7:0] MAX_PAIRS_RST = 8'd64;

  // characters the parser looks at
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_ONE   = 8'h31;

  // lengths of the two names that are matched
  localparam logic [3:0] CL_NAME_LEN   = 4'd14;
  localparam logic [3:0] SCGI_NAME_LEN = 4'd4;
  localparam logic [3:0] NAME_POS_MAX  = 4'd15;

  typedef enum logic [1:0] {
    PH_LEN,
    PH_NAME,
    PH_VALUE,
    PH_COMMA
  } phase_t;

  typedef enum logic [3:0] {
    ST_OK          = 4'd0,
    ST_BAD_SIZE    = 4'd1,
    ST_NO_COLON    = 4'd2,
    ST_NO_COMMA    = 4'd3,
    ST_CUT_PAIR    = 4'd4,
    ST_NO_CLEN     = 4'd5,
    ST_EMPTY_LEN   = 4'd6,
    ST_BAD_VERSION = 4'd7,
    ST_TOO_MANY    = 4'd8
  } status_t;

  // per-frame state, apart from the phase and the length counter
  typedef struct packed {
    logic       digit_seen;
    logic [3:0] name_pos;
    logic [1:0] name_matches;   // bit 0: content length name, bit 1: scgi name
    logic [1:0] value_len;      // saturates at 3
    logic       value_is_one;
    logic [7:0] pairs_done;
    logic       version_found;
    status_t    pending_error;
  } frame_t;

  localparam frame_t FRAME_CLEAR = '{
    digit_seen:    1'b0,
    name_pos:      4'd0,
    name_matches:  2'b11,
    value_len:     2'd0,
    value_is_one:  1'b0,
    pairs_done:    8'd0,
    version_found: 1'b0,
    pending_error: ST_OK
  };

  // one result word
  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_header;
    logic       pair_end;
    logic       frame_done;
    status_t    status;
    logic [7:0] pair_count;
  } result_t;

  // characters of the content length name by position
  function automatic logic [7:0] cl_char(input logic [3:0] pos);
    logic [7:0] ch;
    unique case (pos)
      4'd0:    ch = 8'h43;  // C
      4'd1:    ch = 8'h4F;  // O
      4'd2:    ch = 8'h4E;  // N
      4'd3:    ch = 8'h54;  // T
      4'd4:    ch = 8'h45;  // E
      4'd5:    ch = 8'h4E;  // N
      4'd6:    ch = 8'h54;  // T
      4'd7:    ch = 8'h5F;  // _
      4'd8:    ch = 8'h4C;  // L
      4'd9:    ch = 8'h45;  // E
      4'd10:   ch = 8'h4E;  // N
      4'd11:   ch = 8'h47;  // G
      4'd12:   ch = 8'h54;  // T
      4'd13:   ch = 8'h48;  // H
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // characters of SCGI by position
  function automatic logic [7:0] scgi_char(input logic [3:0] pos);
    logic [7:0] ch;
    unique case (pos)
      4'd0:    ch = 8'h53;  // S
      4'd1:    ch = 8'h43;  // C
      4'd2:    ch = 8'h47;  // G
      4'd3:    ch = 8'h49;  // I
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// File: hdl/scgi_in_stage.sv
`timescale 1ns / 1ps

module scgi_in_stage import scgi_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       advance,
  output logic       hold_valid,
  output logic [7:0] hold_byte
);

  // the held word may be replaced whenever it is empty or moves on this cycle
  assign in_ready = !hold_valid || advance;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hold_byte <= in_byte;
    end
  end

endmodule

// File: hdl/scgi_step.sv
`timescale 1ns / 1ps

module scgi_step import scgi_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  phase_t                 phase,
  input  frame_t                 frame,
  input  logic [LENGTH_BITS-1:0] bytes_left,
  input  logic [7:0]             in_byte,
  input  logic [7:0]             max_pairs,
  output phase_t                 phase_next,
  output frame_t                 frame_next,
  output logic [LENGTH_BITS-1:0] bytes_left_next,
  output result_t                res
);

  localparam int VW = LENGTH_BITS + 4;

  logic                   is_digit;
  logic                   is_colon;
  logic                   is_nul;
  logic                   in_payload;
  logic [VW-1:0]          len_ext;
  logic [VW-1:0]          len_val;
  logic                   len_ovf;
  logic [LENGTH_BITS-1:0] bl_dec;
  logic                   last;
  logic                   done;
  logic                   closes_pair;
  logic [7:0]             pairs_inc;
  logic                   too_many;
  status_t                pair_err;
  logic                   pair_ver;
  logic                   cut;

  // byte decode
  assign is_digit   = (in_byte >= 8'h30) && (in_byte <= 8'h39);
  assign is_colon   = (in_byte == CH_COLON);
  assign is_nul     = (in_byte == CH_NUL);
  assign in_payload = (phase == PH_NAME) || (phase == PH_VALUE);

  // length accumulate: value * 10 + digit, overflow when upper bits set
  assign len_ext = {4'b0000, bytes_left};
  assign len_val = (len_ext << 3) + (len_ext << 1) + VW'(in_byte[3:0]);
  assign len_ovf = |len_val[VW-1:LENGTH_BITS];

  // payload countdown
  assign bl_dec = bytes_left - LENGTH_BITS'(1);
  assign last   = in_payload && (bl_dec == '0);

  // frame end: any length error, or the trailing byte
  assign done = ((phase == PH_LEN) &&
                 ((is_digit && len_ovf) ||
                  (is_colon && !frame.digit_seen) ||
                  (!is_digit && !is_colon))) ||
                (phase == PH_COMMA);

  // pair completion
  assign closes_pair = (phase == PH_VALUE) && is_nul;
  assign pairs_inc   = (frame.pairs_done == 8'hFF) ? frame.pairs_done
                                                   : frame.pairs_done + 8'd1;
  assign too_many    = (pairs_inc >= max_pairs);

  // check of a completed pair, first error only
  always_comb begin
    pair_err = frame.pending_error;
    pair_ver = frame.version_found;
    if (frame.pending_error == ST_OK) begin
      if (frame.pairs_done == 8'd0) begin
        priority if (!frame.name_matches[0]) begin
          pair_err = ST_NO_CLEN;
        end else if (frame.value_len == 2'd0) begin
          pair_err = ST_EMPTY_LEN;
        end else if (too_many) begin
          pair_err = ST_TOO_MANY;
        end else begin
          pair_err = ST_OK;
        end
      end else begin
        priority if (too_many) begin
          pair_err = ST_TOO_MANY;
        end else if (frame.name_matches[1] && !frame.version_found) begin
          if ((frame.value_len == 2'd1) && frame.value_is_one) begin
            pair_ver = 1'b1;
          end else begin
            pair_err = ST_BAD_VERSION;
          end
        end else begin
          pair_err = ST_OK;
        end
      end
    end
  end

  // payload ending inside a name or a value
  assign cut = (phase == PH_NAME) || ((phase == PH_VALUE) && !is_nul);

  // next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_LEN: begin
        if (is_colon && frame.digit_seen) begin
          phase_next = (bytes_left == '0) ? PH_COMMA : PH_NAME;
        end
      end
      PH_NAME: begin
        if (last) begin
          phase_next = PH_COMMA;
        end else if (is_nul) begin
          phase_next = PH_VALUE;
        end
      end
      PH_VALUE: begin
        if (last) begin
          phase_next = PH_COMMA;
        end else if (is_nul) begin
          phase_next = PH_NAME;
        end
      end
      PH_COMMA: phase_next = PH_LEN;
      default:  phase_next = PH_LEN;
    endcase
  end

  // next frame state and length counter
  always_comb begin
    frame_next      = frame;
    bytes_left_next = bytes_left;
    unique case (phase)
      PH_LEN: begin
        if (is_digit) begin
          if (!len_ovf) begin
            bytes_left_next       = len_val[LENGTH_BITS-1:0];
            frame_next.digit_seen = 1'b1;
          end
        end else if (is_colon && frame.digit_seen && (bytes_left == '0)) begin
          frame_next.pending_error = ST_NO_CLEN;
        end
      end
      PH_NAME: begin
        if (is_nul) begin
          frame_next.name_matches = {
            frame.name_matches[1] && (frame.name_pos == SCGI_NAME_LEN),
            frame.name_matches[0] && (frame.name_pos == CL_NAME_LEN)
          };
          frame_next.name_pos     = 4'd0;
          frame_next.value_len    = 2'd0;
          frame_next.value_is_one = 1'b0;
        end else begin
          if (!((frame.name_pos < CL_NAME_LEN) && (cl_char(frame.name_pos) == in_byte))) begin
            frame_next.name_matches[0] = 1'b0;
          end
          if (!((frame.name_pos < SCGI_NAME_LEN) &&
                (scgi_char(frame.name_pos) == in_byte))) begin
            frame_next.name_matches[1] = 1'b0;
          end
          if (frame.name_pos < NAME_POS_MAX) begin
            frame_next.name_pos = frame.name_pos + 4'd1;
          end
        end
      end
      PH_VALUE: begin
        if (is_nul) begin
          frame_next.pairs_done    = pairs_inc;
          frame_next.pending_error = pair_err;
          frame_next.version_found = pair_ver;
          frame_next.name_pos      = 4'd0;
          frame_next.name_matches  = 2'b11;
        end else begin
          if ((frame.value_len == 2'd0) && (in_byte == CH_ONE)) begin
            frame_next.value_is_one = 1'b1;
          end
          if (frame.value_len != 2'd3) begin
            frame_next.value_len = frame.value_len + 2'd1;
          end
        end
      end
      PH_COMMA: begin
      end
      default: begin
      end
    endcase

    // countdown and end-of-payload checks
    if (in_payload) begin
      bytes_left_next = bl_dec;
      if (last && (frame_next.pending_error == ST_OK)) begin
        if (cut) begin
          frame_next.pending_error = ST_CUT_PAIR;
        end else if (frame_next.pairs_done == 8'd0) begin
          frame_next.pending_error = ST_NO_CLEN;
        end
      end
    end

    if (done) begin
      frame_next      = FRAME_CLEAR;
      bytes_left_next = '0;
    end
  end

  // result word
  always_comb begin
    res.out_byte   = ((phase == PH_NAME) && is_nul) ? CH_EQ : in_byte;
    res.is_header  = in_payload;
    res.pair_end   = closes_pair;
    res.frame_done = done;
    res.pair_count = closes_pair ? pairs_inc : frame.pairs_done;
    res.status     = ST_OK;
    unique case (phase)
      PH_LEN: begin
        if (done) begin
          res.status = (is_digit || is_colon) ? ST_BAD_SIZE : ST_NO_COLON;
        end
      end
      PH_COMMA: begin
        priority if (in_byte != CH_COMMA) begin
          res.status = ST_NO_COMMA;
        end else if (frame.pending_error != ST_OK) begin
          res.status = frame.pending_error;
        end else if (!frame.version_found) begin
          res.status = ST_BAD_VERSION;
        end else begin
          res.status = ST_OK;
        end
      end
      PH_NAME, PH_VALUE: res.status = ST_OK;
      default:           res.status = ST_OK;
    endcase
  end

endmodule

// File: hdl/scgi_header_stream_parser.sv
`timescale 1ns / 1ps

// SCGI header stream parser
// Input channel (in_valid / in_ready / in_byte) carries one raw stream byte
// per word. Output channel (out_valid / out_ready) carries one result word
// per input word: the echoed byte, header/pair markers, the frame end flag,
// its status and the running pair count.
// Configuration channel (cfg_valid / cfg_ready / cfg_data) writes max_pairs;
// it is always ready and should only be written while the parser is idle.
// Registers: a word passes through two register stages in all, the input
// register and then the result register.
// Throughput: one word per cycle while out_ready stays high, set by the single
// frame-state update that sits between the input register and the result register.
// Reset: the frame state returns to expecting length digits, both word
// registers empty, max_pairs back to 64.
// Output stall: the result register holds; the input register takes a word
// only while it is empty, then in_ready drops until out_ready returns.
module scgi_header_stream_parser import scgi_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       is_header,
  output logic       pair_end,
  output logic       frame_done,
  output logic [3:0] status,
  output logic [7:0] pair_count,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  logic                   advance;
  logic                   step_en;
  logic                   hold_valid;
  logic [7:0]             hold_byte;
  logic [7:0]             max_pairs;
  phase_t                 phase;
  phase_t                 phase_next;
  frame_t                 frame;
  frame_t                 frame_next;
  logic [LENGTH_BITS-1:0] bytes_left;
  logic [LENGTH_BITS-1:0] bytes_left_next;
  result_t                res_next;
  result_t                res;

  // result register free or being drained
  assign advance = !out_valid || out_ready;
  assign step_en = advance && hold_valid;

  scgi_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .advance    (advance),
    .hold_valid (hold_valid),
    .hold_byte  (hold_byte)
  );

  scgi_step #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_step (
    .phase           (phase),
    .frame           (frame),
    .bytes_left      (bytes_left),
    .in_byte         (hold_byte),
    .max_pairs       (max_pairs),
    .phase_next      (phase_next),
    .frame_next      (frame_next),
    .bytes_left_next (bytes_left_next),
    .res             (res_next)
  );

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_pairs <= MAX_PAIRS_RST;
    end else if (cfg_valid) begin
      max_pairs <= cfg_data;
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_LEN;
      frame      <= FRAME_CLEAR;
      bytes_left <= '0;
    end else if (step_en) begin
      phase      <= phase_next;
      frame      <= frame_next;
      bytes_left <= bytes_left_next;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= hold_valid;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (step_en) begin
      res <= res_next;
    end
  end

  assign out_byte   = res.out_byte;
  assign is_header  = res.is_header;
  assign pair_end   = res.pair_end;
  assign frame_done = res.frame_done;
  assign status     = res.status;
  assign pair_count = res.pair_count;

endmodule

// File: hdl/scgi_checker.sv
`timescale 1ns / 1ps
`include "scgi_header_stream_parser_macros.svh"

module scgi_checker import scgi_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       is_header,
  input logic       pair_end,
  input logic       frame_done,
  input logic [3:0] status
);

  // a nonzero status only comes with the end of a frame
  `SCGI_ASSERT_NOW(a_status_needs_done, out_valid && !frame_done, status == ST_OK, "status set without frame end")

  // a closing NUL lies inside the header and does not end the frame
  `SCGI_ASSERT_NOW(a_pair_end_in_header, out_valid && pair_end, is_header && !frame_done, "pair end outside header")

  // the value-closing NUL is echoed unchanged
  `SCGI_ASSERT_NOW(a_pair_end_is_nul, out_valid && pair_end, out_byte == CH_NUL, "pair end word not NUL")

  // a stalled result word holds
  `SCGI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(status), "stalled result changed")

endmodule

bind scgi_header_stream_parser scgi_checker u_scgi_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_byte   (out_byte),
  .is_header  (is_header),
  .pair_end   (pair_end),
  .frame_done (frame_done),
  .status     (status)
);
